// ===== rtl/core/dmgc_pkg.sv =====
// Shared types, constants and capture-machine function for the DFA matcher.
// No dependencies; used by the RAM-facing core and the top level.
package dmgc_pkg;
  localparam int NumStates  = 64;
  localparam int NumSymbols = 26;
  localparam int NumGroups  = 8;
  localparam int PosBits    = 16;
  localparam int StBits     = $clog2(NumStates);
  localparam int SymBits    = 5;
  localparam int GrpBits    = $clog2(NumGroups);
  localparam int TrDepth    = NumStates * 32;
  localparam int TrAddrBits = $clog2(TrDepth);
  localparam int ActBits    = 2 * NumGroups;
  localparam logic [PosBits-1:0] PosMax = '1;

  typedef enum logic [2:0] {
    REQ_WR_TRANS = 3'd0,
    REQ_WR_ACT   = 3'd1,
    REQ_WR_TERM  = 3'd2,
    REQ_SYMBOL   = 3'd3,
    REQ_END      = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_EMIT = 2'd2
  } st_t;

  localparam logic [1:0] ActNone = 2'd0;
  localparam logic [1:0] ActB    = 2'd1;
  localparam logic [1:0] ActE    = 2'd2;
  localparam logic [1:0] ActBE   = 2'd3;

  localparam logic [2:0] ModeInit    = 3'd0;
  localparam logic [2:0] ModePlain   = 3'd1;
  localparam logic [2:0] ModeStarGrp = 3'd2;
  localparam logic [2:0] ModeGrpStar = 3'd3;
  localparam logic [2:0] ModeFirst   = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic [PosBits-1:0] start;
    logic [1:0]         last;
  } grp_t;

  typedef struct packed {
    logic               emit;
    logic [PosBits-1:0] rbeg;
    logic               ext;
  } gev_t;

  // One capture event for one group; returns the updated group and any range.
  function automatic grp_t grp_step(input grp_t g, input logic [1:0] act,
                                    input logic [PosBits-1:0] pos, output gev_t ev);
    grp_t n;
    logic ok;
    n = g;
    ok = 1'b1;
    ev = '0;
    ev.rbeg = g.start;
    unique case (g.mode)
      ModeInit: begin
        if (act == ActE) ok = 1'b0;
        else begin
          n.mode = (act == ActB) ? ModeFirst : ModeGrpStar;
          n.start = pos;
        end
      end
      ModeFirst: begin
        if (act == ActE) begin
          n.mode = ModePlain;
          ev.emit = 1'b1;
        end else begin
          n.mode = ModeStarGrp;
          ev.emit = (act == ActBE);
          n.start = pos;
        end
      end
      ModePlain: begin
        if (act == ActBE) ok = 1'b0;
        else if (act == ActB) begin
          if (g.last != ActE) ok = 1'b0;
          else n.start = pos;
        end else begin
          if (g.last != ActB) ok = 1'b0;
          else ev.emit = 1'b1;
        end
      end
      ModeStarGrp: begin
        if (act == ActE) ok = 1'b0;
        else begin
          ev.emit = (act == ActBE);
          n.start = pos;
        end
      end
      ModeGrpStar: begin
        if (act == ActB) ok = 1'b0;
        else if (act == ActBE) n.start = pos;
        else begin
          ev.emit = 1'b1;
          ev.ext = (g.last != ActBE);
        end
      end
      default: ok = 1'b0;
    endcase
    if (act == ActNone) ok = 1'b0;
    if (!ok) begin
      n = g;
      ev.emit = 1'b0;
    end else begin
      n.last = act;
    end
    return n;
  endfunction
endpackage

// ===== rtl/core/dfa_matcher_with_group_capture_top.sv =====
// DFA matcher with capture groups. Table writes and ignored requests complete on accept.
// A symbol or end request moves from the accept into S_READ, where the tables are read
// and every group steps at once, then into S_EMIT, which sends the results one at a time
// (up to 9 for an end) and holds while out_tready is low; a symbol with no result
// returns from S_READ to idle. Synchronous active-low reset clears state, position,
// dead flag, groups and the output valid flag; tables are undefined.
module dfa_matcher_with_group_capture_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // state_index[5:0], symbol[10:6], next_state[16:11], next_valid[17],
  // group_index[20:18], action_code[22:21], terminal_flag[23]
  input  logic [23:0] in_tdata,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // group_id[2:0], range_begin[18:3], range_end[34:19], extend_last[35],
  // matched[36]
  output logic [39:0] out_tdata,
  // kind[0]
  output logic        out_tuser,
  output logic        out_tlast
);
  import dmgc_pkg::*;

  logic [2:0]  rt;
  logic [5:0]  si, nx;
  logic [4:0]  sym;
  logic        nv, tf;
  logic [2:0]  gi;
  logic [1:0]  ac;
  assign rt  = in_tuser;
  assign si  = in_tdata[5:0];
  assign sym = in_tdata[10:6];
  assign nx  = in_tdata[16:11];
  assign nv  = in_tdata[17];
  assign gi  = in_tdata[20:18];
  assign ac  = in_tdata[22:21];
  assign tf  = in_tdata[23];

  st_t st_r, st_nxt;
  logic [StBits-1:0]    cur_r, cur_nxt;
  logic                 dead_r, dead_nxt;
  logic [PosBits-1:0]   pos_r, pos_nxt;
  grp_t                 grp_r [NumGroups];
  grp_t                 grp_nxt [NumGroups];
  logic                 is_end_r, is_end_nxt;
  logic [SymBits-1:0]   sym_r, sym_nxt;
  logic [NumGroups-1:0] emask_r, emask_nxt;
  logic [PosBits-1:0]   ebeg_r [NumGroups];
  logic [PosBits-1:0]   ebeg_nxt [NumGroups];
  logic [NumGroups-1:0] eext_r, eext_nxt;
  logic [PosBits-1:0]   epos_r, epos_nxt;
  logic                 match_r, match_nxt;
  logic                 ob_v_r, ob_v_nxt;
  logic [39:0]          ob_d_r, ob_d_nxt;
  logic                 ob_k_r, ob_k_nxt;
  logic                 ob_l_r, ob_l_nxt;

  logic [StBits:0]     tr_q;
  logic [ActBits-1:0]  act_q;
  logic                term_q;
  logic                acc;
  logic                wr_tr, wr_act, wr_term;

  assign acc = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign wr_tr   = acc && rt == REQ_WR_TRANS && sym < SymBits'(NumSymbols);
  assign wr_act  = acc && rt == REQ_WR_ACT;
  assign wr_term = acc && rt == REQ_WR_TERM;

  dmgc_tables u_tab (
    .clk(clk), .wr_tr(wr_tr), .wr_act(wr_act), .wr_term(wr_term),
    .w_state(si), .w_sym(sym), .w_tr({nv, nx}), .w_grp(gi), .w_act(ac),
    .w_term(tf), .r_state(cur_r), .r_sym(sym), .tr_q(tr_q), .act_q(act_q),
    .term_q(term_q));

  assign out_tvalid = ob_v_r;
  assign out_tdata  = ob_d_r;
  assign out_tuser  = ob_k_r;
  assign out_tlast  = ob_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cur_r <= '0;
      dead_r <= 1'b0;
      pos_r <= '0;
      ob_v_r <= 1'b0;
      for (int g = 0; g < NumGroups; g++) grp_r[g] <= '0;
    end else begin
      st_r <= st_nxt;
      cur_r <= cur_nxt;
      dead_r <= dead_nxt;
      pos_r <= pos_nxt;
      ob_v_r <= ob_v_nxt;
      for (int g = 0; g < NumGroups; g++) grp_r[g] <= grp_nxt[g];
    end
    is_end_r <= is_end_nxt;
    sym_r <= sym_nxt;
    emask_r <= emask_nxt;
    eext_r <= eext_nxt;
    epos_r <= epos_nxt;
    match_r <= match_nxt;
    for (int g = 0; g < NumGroups; g++) ebeg_r[g] <= ebeg_nxt[g];
    ob_d_r <= ob_d_nxt;
    ob_k_r <= ob_k_nxt;
    ob_l_r <= ob_l_nxt;
  end

  // All groups see their action in the read cycle; each machine is independent.
  grp_t upd_g [NumGroups];
  gev_t ev_g [NumGroups];
  always_comb begin
    gev_t ev;
    for (int g = 0; g < NumGroups; g++) begin
      upd_g[g] = grp_step(grp_r[g], dead_r ? ActNone : act_q[2*g +: 2], pos_r, ev);
      ev_g[g] = ev;
    end
  end

  // Lowest group with a pending range, and what is left after it.
  logic [GrpBits-1:0]   first_g;
  logic [NumGroups-1:0] rest_mask;
  always_comb begin
    first_g = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (emask_r[g]) first_g = GrpBits'(g);
    end
    rest_mask = emask_r;
    rest_mask[first_g] = 1'b0;
  end

  always_comb begin
    st_nxt = st_r;
    cur_nxt = cur_r;
    dead_nxt = dead_r;
    pos_nxt = pos_r;
    for (int g = 0; g < NumGroups; g++) grp_nxt[g] = grp_r[g];
    is_end_nxt = is_end_r;
    sym_nxt = sym_r;
    emask_nxt = emask_r;
    for (int g = 0; g < NumGroups; g++) ebeg_nxt[g] = ebeg_r[g];
    eext_nxt = eext_r;
    epos_nxt = epos_r;
    match_nxt = match_r;
    ob_v_nxt = ob_v_r && !out_tready;
    ob_d_nxt = ob_d_r;
    ob_k_nxt = ob_k_r;
    ob_l_nxt = ob_l_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc && ((rt == REQ_SYMBOL && !dead_r) || rt == REQ_END)) begin
          st_nxt = S_READ;
          is_end_nxt = (rt == REQ_END);
          sym_nxt = sym;
        end
      end
      S_READ: begin
        for (int g = 0; g < NumGroups; g++) begin
          emask_nxt[g] = ev_g[g].emit;
          ebeg_nxt[g] = ev_g[g].rbeg;
          eext_nxt[g] = ev_g[g].ext;
        end
        epos_nxt = pos_r;
        match_nxt = !dead_r && term_q;
        if (is_end_r) begin
          // The run is over once its ranges are latched; only output remains.
          cur_nxt = '0;
          dead_nxt = 1'b0;
          pos_nxt = '0;
          for (int g = 0; g < NumGroups; g++) grp_nxt[g] = '0;
          st_nxt = S_EMIT;
        end else begin
          for (int g = 0; g < NumGroups; g++) grp_nxt[g] = upd_g[g];
          if (sym_r < SymBits'(NumSymbols) && tr_q[StBits]) begin
            cur_nxt = tr_q[StBits-1:0];
            if (pos_r != PosMax) pos_nxt = pos_r + 1'b1;
          end else begin
            dead_nxt = 1'b1;
          end
          st_nxt = (emask_nxt != '0) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!ob_v_nxt) begin
          ob_v_nxt = 1'b1;
          if (emask_r != '0) begin
            ob_k_nxt = 1'b0;
            ob_d_nxt = {3'b000, 1'b0, eext_r[first_g], epos_r, ebeg_r[first_g], first_g};
            ob_l_nxt = (rest_mask == '0) && !is_end_r;
            emask_nxt = rest_mask;
            if (rest_mask == '0 && !is_end_r) st_nxt = S_IDLE;
          end else begin
            ob_k_nxt = 1'b1;
            ob_d_nxt = {3'b000, match_r, 1'b0, 16'd0, 16'd0, 3'd0};
            ob_l_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/core/dmgc_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module dmgc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/dmgc_tables.sv =====
// Table stores of the matcher: transitions, accepting bits, state actions.
// Depends on dmgc_pkg and dmgc_ram.
module dmgc_tables (
  input  logic                        clk,
  input  logic                        wr_tr,
  input  logic                        wr_act,
  input  logic                        wr_term,
  input  logic [dmgc_pkg::StBits-1:0] w_state,
  input  logic [dmgc_pkg::SymBits-1:0] w_sym,
  input  logic [dmgc_pkg::StBits:0]   w_tr,
  input  logic [dmgc_pkg::GrpBits-1:0] w_grp,
  input  logic [1:0]                  w_act,
  input  logic                        w_term,
  input  logic [dmgc_pkg::StBits-1:0] r_state,
  input  logic [dmgc_pkg::SymBits-1:0] r_sym,
  output logic [dmgc_pkg::StBits:0]   tr_q,
  output logic [dmgc_pkg::ActBits-1:0] act_q,
  output logic                        term_q
);
  import dmgc_pkg::*;

  // Action row updated per group: rather than a read-modify-write of a shared row,
  // each group's 2 bits live in their own narrow RAM.
  logic [1:0] act_row [NumGroups];

  dmgc_ram #(.Width(StBits + 1), .Depth(TrDepth)) u_tr (
    .clk(clk), .we(wr_tr), .waddr({w_state, w_sym}), .wdata(w_tr),
    .raddr({r_state, r_sym}), .rdata(tr_q));

  dmgc_ram #(.Width(1), .Depth(NumStates)) u_term (
    .clk(clk), .we(wr_term), .waddr(w_state), .wdata(w_term),
    .raddr(r_state), .rdata(term_q));

  for (genvar g = 0; g < NumGroups; g++) begin : g_act
    dmgc_ram #(.Width(2), .Depth(NumStates)) u_act (
      .clk(clk), .we(wr_act && (w_grp == GrpBits'(g))), .waddr(w_state),
      .wdata(w_act), .raddr(r_state), .rdata(act_row[g]));
    assign act_q[2*g +: 2] = act_row[g];
  end
endmodule
